// ===== rtl/ps2mt_pkg.sv =====
// ps2mt_pkg: shared types, register indexes and constants for the ps/2 mouse packet tracker
// depends on nothing; imported by every rtl module of the block
`timescale 1ns / 1ps

package ps2mt_pkg;

  // coordinate width default
  localparam int COORD_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_ENABLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_X        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_Y        = 3'd4;

  // register reset values
  localparam logic [15:0] SCREEN_WIDTH_RST  = 16'd1024;
  localparam logic [15:0] SCREEN_HEIGHT_RST = 16'd768;
  localparam logic        CLAMP_ENABLE_RST  = 1'b0;
  localparam logic [15:0] HOME_X_RST        = 16'd512;
  localparam logic [15:0] HOME_Y_RST        = 16'd384;

  // header byte layout
  localparam int SYNC_BIT   = 3;   // always set in a header byte
  localparam int OVF_X_BIT  = 6;
  localparam int OVF_Y_BIT  = 7;
  localparam int BUTTONS_W  = 3;   // low bits of the header

  // substitution values for an overflowed delta
  localparam logic signed [8:0] DELTA_OVF_NEG = -9'sd127;
  localparam logic signed [8:0] DELTA_OVF_POS = 9'sd127;

  // byte position within a packet
  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_X    = 3'b010,
    PH_Y    = 3'b100
  } phase_t;

  // decoded packet, valid when done is set
  typedef struct packed {
    logic                  done;
    logic [BUTTONS_W-1:0]  buttons;
    logic signed [7:0]     delta_x;
    logic signed [8:0]     delta_y;
  } pkt_t;

endpackage

// ===== rtl/ps2mt_frame.sv =====
// ps2mt_frame: byte framing of 3-byte ps/2 packets and delta decoding
// depends on ps2mt_pkg
`timescale 1ns / 1ps

module ps2mt_frame
  import ps2mt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] data_byte,
  output pkt_t       pkt
);

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] header;
  logic [7:0] x_byte;

  logic signed [7:0] dx_raw;
  logic signed [8:0] dy_raw;
  logic signed [8:0] dx_sub;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEAD: begin
        if (data_byte[SYNC_BIT]) phase_next = PH_X;
      end
      PH_X:    phase_next = PH_Y;
      PH_Y:    phase_next = PH_HEAD;
      default: phase_next = PH_HEAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEAD;
      header <= '0;
      x_byte <= '0;
    end else if (advance) begin
      phase <= phase_next;
      if (phase == PH_HEAD && data_byte[SYNC_BIT]) header <= data_byte;
      if (phase == PH_X) x_byte <= data_byte;
    end
  end

  // y is reported up-positive, screen is down-positive
  assign dx_raw = $signed(x_byte);
  assign dy_raw = 9'sd0 - $signed({data_byte[7], data_byte});

  assign dx_sub = (dx_raw > 8'sd0) ? DELTA_OVF_NEG : DELTA_OVF_POS;

  always_comb begin
    pkt.done    = (phase == PH_Y);
    pkt.buttons = header[BUTTONS_W-1:0];
    pkt.delta_x = header[OVF_X_BIT] ? dx_sub[7:0] : dx_raw;
    if (header[OVF_Y_BIT]) begin
      pkt.delta_y = (dy_raw > 9'sd0) ? DELTA_OVF_NEG : DELTA_OVF_POS;
    end else begin
      pkt.delta_y = dy_raw;
    end
  end

endmodule

// ===== rtl/ps2mt_axis.sv =====
// ps2mt_axis: one cursor coordinate with move, saturate, clamp and home load
// depends on ps2mt_pkg
`timescale 1ns / 1ps

module ps2mt_axis
  import ps2mt_pkg::*;
#(
  parameter int          COORD_BITS = COORD_BITS_DEF,
  parameter logic [15:0] HOME_RESET = HOME_X_RST
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic signed [8:0] delta,
  input  logic [15:0]       size,
  input  logic              clamp_en,
  input  logic              load,
  input  logic [15:0]       load_val,
  output logic [15:0]       pos_next16
);

  localparam int SW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
  localparam logic [SW-1:0] MAXV = {{(SW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

  function automatic logic [COORD_BITS-1:0] sat(input logic [SW-1:0] v);
    logic [COORD_BITS-1:0] r;
    r = (v > MAXV) ? MAXV[COORD_BITS-1:0] : v[COORD_BITS-1:0];
    return r;
  endfunction

  logic [COORD_BITS-1:0] cur;
  logic [COORD_BITS-1:0] cur_next;
  logic signed [SW-1:0]  sum;
  logic [SW-1:0]         sum_pos;
  logic [COORD_BITS-1:0] sat_val;
  logic [SW-1:0]         sat_ext;
  logic [15:0]           lim;
  logic [SW-1:0]         lim_ext;
  logic [SW-1:0]         next_ext;

  assign sum = $signed({{(SW-COORD_BITS){1'b0}}, cur}) + $signed({{(SW-9){delta[8]}}, delta});
  // floor at zero, then saturate at the coordinate maximum
  assign sum_pos = sum[SW-1] ? '0 : sum;
  assign sat_val = sat(sum_pos);
  assign sat_ext = {{(SW-COORD_BITS){1'b0}}, sat_val};

  assign lim     = (size == 16'd0) ? 16'd0 : size - 16'd1;
  assign lim_ext = {{(SW-16){1'b0}}, lim};

  assign cur_next   = (clamp_en && sat_ext > lim_ext) ? lim_ext[COORD_BITS-1:0] : sat_val;
  assign next_ext   = {{(SW-COORD_BITS){1'b0}}, cur_next};
  assign pos_next16 = next_ext[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= sat({{(SW-16){1'b0}}, HOME_RESET});
    end else if (load) begin
      cur <= sat({{(SW-16){1'b0}}, load_val});
    end else if (step) begin
      cur <= cur_next;
    end
  end

endmodule

// ===== rtl/ps2_mouse_packet_tracker_top.sv =====
// ps2_mouse_packet_tracker_top: top level of the ps/2 mouse packet tracker
// depends on ps2mt_pkg, ps2mt_frame, ps2mt_axis
`timescale 1ns / 1ps

// usage
//   input channel: one mouse byte per request on data_byte (in_valid/in_ready).
//   bytes are framed into 3-byte packets; while hunting for a header, bytes
//   with bit 3 clear are dropped. the third byte of a packet yields one result
//   request on the output channel (out_valid/out_ready) carrying the new cursor
//   position, buttons and the applied deltas.
//   path: a byte is held in the input register, then its result is loaded into
//   the output register once that register is free.
//   throughput: one byte per cycle when not stalled, set by the single-pass
//   update of the position registers between the input and result registers.
//   stall: a stalled result holds the output register; the input register
//   keeps taking header and x bytes, and stops only when a third byte finds
//   the output register still occupied, which then deasserts in_ready.
//   reset (rst, synchronous): byte framing restarts at a header, registers go
//   to width 1024, height 768, clamp off, and the cursor goes home (512, 384).
//   config: cfg_we writes register cfg_index at once; writing home_x or
//   home_y moves only the cursor. write only while the block is idle.

module ps2_mouse_packet_tracker_top
  import ps2mt_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // byte input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           pos_x,
  output logic [15:0]           pos_y,
  output logic [BUTTONS_W-1:0]  buttons,
  output logic signed [7:0]     delta_x,
  output logic signed [8:0]     delta_y,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [15:0] screen_width;
  logic [15:0] screen_height;
  logic        clamp_enable;
  logic        load_x;
  logic        load_y;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_adv;
  logic       out_free;
  logic       res_load;

  pkt_t        pkt;
  logic [15:0] pos_x_next;
  logic [15:0] pos_y_next;

  // register decode; home writes load the cursor
  always_comb begin
    load_x = 1'b0;
    load_y = 1'b0;
    unique case (cfg_index)
      CFG_HOME_X: load_x = cfg_we;
      CFG_HOME_Y: load_y = cfg_we;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
      clamp_enable  <= CLAMP_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[15:0];
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data[15:0];
        CFG_CLAMP_ENABLE:  clamp_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a byte leaves the input register unless it completes a packet and the
  // result slot is still held by the receiver
  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && (!pkt.done || out_free);
  assign res_load = s1_adv && pkt.done;
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte <= data_byte;
  end

  ps2mt_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .advance   (s1_adv),
    .data_byte (s1_byte),
    .pkt       (pkt)
  );

  ps2mt_axis #(
    .COORD_BITS (COORD_BITS),
    .HOME_RESET (HOME_X_RST)
  ) u_axis_x (
    .clk        (clk),
    .rst        (rst),
    .step       (res_load),
    .delta      ({pkt.delta_x[7], pkt.delta_x}),
    .size       (screen_width),
    .clamp_en   (clamp_enable),
    .load       (load_x),
    .load_val   (cfg_data[15:0]),
    .pos_next16 (pos_x_next)
  );

  ps2mt_axis #(
    .COORD_BITS (COORD_BITS),
    .HOME_RESET (HOME_Y_RST)
  ) u_axis_y (
    .clk        (clk),
    .rst        (rst),
    .step       (res_load),
    .delta      (pkt.delta_y),
    .size       (screen_height),
    .clamp_en   (clamp_enable),
    .load       (load_y),
    .load_val   (cfg_data[15:0]),
    .pos_next16 (pos_y_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      pos_x   <= pos_x_next;
      pos_y   <= pos_y_next;
      buttons <= pkt.buttons;
      delta_x <= pkt.delta_x;
      delta_y <= pkt.delta_y;
    end
  end

  // a new result only ever comes from a completed packet
  a_result_from_packet: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(res_load))
    else $error("result appeared without a completed packet");

  // a held byte in the input register is not lost or altered
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_byte)))
    else $error("stalled input byte lost or changed");

  // with clamping on and a nonzero screen width, a fresh x result stays inside it
  a_clamp_x: assert property (@(posedge clk) disable iff (rst)
    (res_load && clamp_enable && screen_width != 16'd0) |=> (pos_x < $past(screen_width)))
    else $error("x position outside clamp range");

endmodule
